// ===== rtl/opt_reuse_window_oracle_assert.svh =====
// ----------------------------------------------------------------------------
// Reuse window oracle assertion macros
// Concurrent assertion wrappers clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OPT_REUSE_WINDOW_ORACLE_ASSERT_SVH
`define OPT_REUSE_WINDOW_ORACLE_ASSERT_SVH

`ifndef SYNTHESIS

`define ORWO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ORWO_ASSERT_IMPL(lbl, ante, cons, msg) `ORWO_ASSERT(lbl, (ante) |-> (cons), msg)

`define ORWO_ASSERT_NEXT(lbl, ante, cons, msg) `ORWO_ASSERT(lbl, (ante) |=> (cons), msg)

`else

`define ORWO_ASSERT(lbl, prop, msg)

`define ORWO_ASSERT_IMPL(lbl, ante, cons, msg)

`define ORWO_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/orwo_pkg.sv =====
// ----------------------------------------------------------------------------
// Reuse window oracle package
// Sizes and the command/status bundles shared by controller and datapath.
// ----------------------------------------------------------------------------
package orwo_pkg;

  localparam int WAYS              = 16;
  localparam int SETS              = 64;
  localparam int HISTORY_MAX       = 128;
  localparam int BLOCK_OFFSET_BITS = 6;

  localparam int ADDR_IN_W = 64;
  localparam int SET_IN_W  = 6;
  localparam int HLEN_W    = 8;

  localparam int LINE_W = ADDR_IN_W - BLOCK_OFFSET_BITS;
  localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SLOT_W = $clog2(HISTORY_MAX);
  localparam int FILL_W = $clog2(HISTORY_MAX + 1);
  localparam int OCC_W  = $clog2(WAYS + 1);
  localparam int ADDR_W = $clog2(SETS * HISTORY_MAX);

  typedef struct packed {
    logic load;       // latch transaction, read set metadata
    logic append;     // trim window, write new entry
    logic search;     // walk window backward
    logic start_inc;  // arm increment walk at matched entry
    logic inc;        // increment walk
  } orwo_cmd_t;

  typedef struct packed {
    logic cmp_vld;
    logic tag_eq;
    logic occ_full;
    logic last_pos;
    logic search_idle;
    logic inc_idle;
  } orwo_status_t;

endpackage

// ===== rtl/orwo_datapath.sv =====
// ----------------------------------------------------------------------------
// Reuse window oracle datapath
// Window tag/occupancy memories, per-set metadata and walk counters.
// ----------------------------------------------------------------------------
`include "opt_reuse_window_oracle_assert.svh"

module orwo_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  orwo_pkg::orwo_cmd_t              cmd_i,
  output orwo_pkg::orwo_status_t           status_o,
  input  logic [orwo_pkg::ADDR_IN_W-1:0]   byte_address_i,
  input  logic [orwo_pkg::SET_IN_W-1:0]    set_index_i,
  input  logic                             history_length_we_i,
  input  logic [orwo_pkg::HLEN_W-1:0]      history_length_i
);
  import orwo_pkg::*;

  function automatic logic [SLOT_W-1:0] wrap_add(input logic [SLOT_W-1:0] base,
                                                 input logic [FILL_W-1:0] off);
    logic [FILL_W:0] sum;
    sum = (FILL_W+1)'(base) + (FILL_W+1)'(off);
    if (sum >= (FILL_W+1)'(HISTORY_MAX)) sum = sum - (FILL_W+1)'(HISTORY_MAX);
    return sum[SLOT_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [SET_W-1:0] set,
                                                 input logic [SLOT_W-1:0] slot);
    return ADDR_W'(ADDR_W'(set) * ADDR_W'(HISTORY_MAX) + ADDR_W'(slot));
  endfunction

  logic [LINE_W-1:0] tag_mem [SETS*HISTORY_MAX];
  logic [OCC_W-1:0]  occ_mem [SETS*HISTORY_MAX];
  logic [FILL_W-1:0] fill_mem [SETS];
  logic [SLOT_W-1:0] old_mem  [SETS];
  logic [SETS-1:0]   meta_vld_q;

  logic [HLEN_W-1:0] hist_len_q;
  logic [LINE_W-1:0] line_q;
  logic [SET_W-1:0]  set_q;
  logic [FILL_W-1:0] m_fill_q;
  logic [SLOT_W-1:0] m_old_q;
  logic              m_hit_q;
  logic [SLOT_W-1:0] base_q;
  logic [SLOT_W-1:0] newest_q;
  logic [SLOT_W-1:0] issue_pos_q;
  logic              issue_active_q;
  logic [SLOT_W-1:0] rd_pos_q;
  logic              rd_vld_q;
  logic [LINE_W-1:0] tag_rd_q;
  logic [OCC_W-1:0]  occ_rd_q;
  logic              full_q;
  logic [SLOT_W-1:0] inc_pos_q;
  logic              inc_active_q;
  logic [SLOT_W-1:0] wr_pos_q;
  logic              wr_vld_q;

  logic [SET_W-1:0]  load_set;
  logic [FILL_W-1:0] m_fill, len, drop, adj_fill;
  logic [SLOT_W-1:0] m_old, adj_old, new_slot, newest;
  logic              rd_en;
  logic [SLOT_W-1:0] rd_slot;
  logic              occ_we;
  logic [ADDR_W-1:0] occ_wa;
  logic [OCC_W-1:0]  occ_wd;

  assign load_set = SET_W'(set_index_i % SETS);

  // window trim and append position
  always_comb begin
    m_fill    = m_hit_q ? m_fill_q : '0;
    m_old     = m_hit_q ? m_old_q : '0;
    if (hist_len_q == '0) begin
      len = FILL_W'(1);
    end else if (int'(hist_len_q) > HISTORY_MAX) begin
      len = FILL_W'(HISTORY_MAX);
    end else begin
      len = FILL_W'(hist_len_q);
    end
    drop = m_fill - (len - FILL_W'(1));
    if (m_fill >= len) begin
      adj_old  = wrap_add(m_old, drop);
      adj_fill = len - FILL_W'(1);
    end else begin
      adj_old  = m_old;
      adj_fill = m_fill;
    end
    newest   = SLOT_W'(adj_fill);
    new_slot = wrap_add(adj_old, adj_fill);
  end

  assign rd_en   = (cmd_i.search && issue_active_q) || (cmd_i.inc && inc_active_q);
  assign rd_slot = wrap_add(base_q, FILL_W'(cmd_i.search ? issue_pos_q : inc_pos_q));

  assign occ_we = cmd_i.append || (cmd_i.inc && wr_vld_q);
  assign occ_wa = cmd_i.append ? mem_addr(set_q, new_slot)
                               : mem_addr(set_q, wrap_add(base_q, FILL_W'(wr_pos_q)));
  assign occ_wd = cmd_i.append ? '0 : occ_rd_q + OCC_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      tag_mem[mem_addr(set_q, new_slot)] <= line_q;
    end
    if (rd_en && cmd_i.search) begin
      tag_rd_q <= tag_mem[mem_addr(set_q, rd_slot)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (occ_we) begin
      occ_mem[occ_wa] <= occ_wd;
    end
    if (rd_en) begin
      occ_rd_q <= occ_mem[mem_addr(set_q, rd_slot)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      fill_mem[set_q] <= adj_fill + FILL_W'(1);
      old_mem[set_q]  <= adj_old;
    end
    if (cmd_i.load) begin
      m_fill_q <= fill_mem[load_set];
      m_old_q  <= old_mem[load_set];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meta_vld_q     <= '0;
      hist_len_q     <= HLEN_W'(128);
      issue_active_q <= 1'b0;
      rd_vld_q       <= 1'b0;
      inc_active_q   <= 1'b0;
      wr_vld_q       <= 1'b0;
    end else begin
      if (history_length_we_i) hist_len_q <= history_length_i;
      if (cmd_i.append) begin
        meta_vld_q[set_q] <= 1'b1;
        issue_active_q    <= (newest != '0);
      end else if (cmd_i.search && issue_active_q) begin
        issue_active_q <= (issue_pos_q != '0);
      end
      rd_vld_q <= cmd_i.search && issue_active_q;
      if (cmd_i.start_inc) begin
        inc_active_q <= 1'b1;
      end else if (cmd_i.inc && inc_active_q) begin
        inc_active_q <= ((inc_pos_q + SLOT_W'(1)) != newest_q);
      end
      wr_vld_q <= cmd_i.inc && inc_active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      line_q  <= byte_address_i[ADDR_IN_W-1:BLOCK_OFFSET_BITS];
      set_q   <= load_set;
      m_hit_q <= meta_vld_q[load_set];
    end
    if (cmd_i.append) begin
      base_q      <= adj_old;
      newest_q    <= newest;
      issue_pos_q <= newest - SLOT_W'(1);
      full_q      <= 1'b0;
    end
    if (cmd_i.search && issue_active_q) begin
      issue_pos_q <= issue_pos_q - SLOT_W'(1);
      rd_pos_q    <= issue_pos_q;
    end
    if (cmd_i.search && rd_vld_q && (occ_rd_q >= OCC_W'(WAYS))) begin
      full_q <= 1'b1;
    end
    if (cmd_i.start_inc) begin
      inc_pos_q <= rd_pos_q;
    end else if (cmd_i.inc && inc_active_q) begin
      inc_pos_q <= inc_pos_q + SLOT_W'(1);
      wr_pos_q  <= inc_pos_q;
    end
  end

  assign status_o.cmp_vld     = rd_vld_q;
  assign status_o.tag_eq      = (tag_rd_q == line_q);
  assign status_o.occ_full    = full_q || (occ_rd_q >= OCC_W'(WAYS));
  assign status_o.last_pos    = (rd_pos_q == '0);
  assign status_o.search_idle = !issue_active_q && !rd_vld_q;
  assign status_o.inc_idle    = !inc_active_q && !wr_vld_q;

  `ORWO_ASSERT_IMPL(a_inc_in_range, inc_active_q, inc_pos_q < newest_q, "increment past newest")
  `ORWO_ASSERT_IMPL(a_wr_in_range, wr_vld_q, wr_pos_q < newest_q, "occupancy write past newest")

endmodule

// ===== rtl/orwo_ctrl.sv =====
// ----------------------------------------------------------------------------
// Reuse window oracle controller
// Sequences metadata read, append, backward search and increment walk.
// ----------------------------------------------------------------------------
`include "opt_reuse_window_oracle_assert.svh"

module orwo_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  output orwo_pkg::orwo_cmd_t    cmd_o,
  input  orwo_pkg::orwo_status_t status_i,
  output logic                   result_valid_o,
  output logic                   opt_hit_o,
  output logic                   reuse_found_o
);
  import orwo_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_META   = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_INC    = 2'd3;

  logic [1:0] state_q, state_d;
  logic       valid_q, valid_d;
  logic       hit_q, hit_d;
  logic       found_q, found_d;

  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    hit_d   = hit_q;
    found_d = found_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_META;
        end
      end
      S_META: begin
        cmd_o.append = 1'b1;
        state_d      = S_SEARCH;
      end
      S_SEARCH: begin
        cmd_o.search = 1'b1;
        if (status_i.cmp_vld && status_i.tag_eq) begin
          if (status_i.occ_full) begin
            valid_d = 1'b1;
            hit_d   = 1'b0;
            found_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            cmd_o.start_inc = 1'b1;
            state_d         = S_INC;
          end
        end else if ((status_i.cmp_vld && status_i.last_pos) || status_i.search_idle) begin
          valid_d = 1'b1;
          hit_d   = 1'b0;
          found_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_INC: begin
        cmd_o.inc = 1'b1;
        if (status_i.inc_idle) begin
          valid_d = 1'b1;
          hit_d   = 1'b1;
          found_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    found_q <= found_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign opt_hit_o      = hit_q;
  assign reuse_found_o  = found_q;

  `ORWO_ASSERT_NEXT(a_strobe_pulse, valid_q, !valid_q, "result strobe longer than one cycle")
  `ORWO_ASSERT_IMPL(a_hit_has_reuse, valid_q && hit_q, found_q, "opt hit without reuse")
  `ORWO_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o, "accepted transaction not busy")
  `ORWO_ASSERT_IMPL(a_result_idle, valid_q, !busy_o, "result while busy")

endmodule

// ===== rtl/opt_reuse_window_oracle.sv =====
// Transactions: one at a time; the window memories are walked one entry per cycle,
//   backward search then increment pass, over up to HISTORY_MAX-1 window entries.
// Reset: asynchronous active low; all windows empty, history_length back to 128.
// ----------------------------------------------------------------------------
// Reuse window oracle top level
// Per-set sliding window tracking whether optimal replacement would hit.
// The result strobe lasts one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module opt_reuse_window_oracle (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [orwo_pkg::ADDR_IN_W-1:0] byte_address_i,
  input  logic [orwo_pkg::SET_IN_W-1:0]  set_index_i,
  input  logic                           history_length_we_i,
  input  logic [orwo_pkg::HLEN_W-1:0]    history_length_i,
  output logic                           result_valid_o,
  output logic                           opt_hit_o,
  output logic                           reuse_found_o
);
  import orwo_pkg::*;

  orwo_cmd_t    cmd;
  orwo_status_t status;

  orwo_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_o          (cmd),
    .status_i       (status),
    .result_valid_o (result_valid_o),
    .opt_hit_o      (opt_hit_o),
    .reuse_found_o  (reuse_found_o)
  );

  orwo_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .byte_address_i      (byte_address_i),
    .set_index_i         (set_index_i),
    .history_length_we_i (history_length_we_i),
    .history_length_i    (history_length_i)
  );

endmodule

// ===== test/opt_reuse_window_oracle_tb.sv =====
// ----------------------------------------------------------------------------
// Reuse window oracle testbench
// Drives line accesses into the per-set OPT window and compares every result
// strobe with a cycle-free model of the window, across several history
// lengths and sender idle patterns.
// ----------------------------------------------------------------------------
module opt_reuse_window_oracle_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import orwo_pkg::*;

  class oracle_scoreboard;
    typedef struct packed {
      logic opt_hit;
      logic reuse_found;
    } verdict_t;

    logic [LINE_W-1:0] tags [SETS*HISTORY_MAX];
    logic [OCC_W-1:0]  occ  [SETS*HISTORY_MAX];
    int unsigned       fill   [SETS];
    int unsigned       oldest [SETS];
    int unsigned       hist_len;
    verdict_t          verdicts [$];
    int unsigned       n_errors;
    int unsigned       n_access;
    int unsigned       n_reuse;
    int unsigned       n_hit;
    int unsigned       n_lengths;

    function new();
      for (int i = 0; i < SETS; i++) begin
        fill[i]   = 0;
        oldest[i] = 0;
      end
      hist_len  = 128;
      n_errors  = 0;
      n_access  = 0;
      n_reuse   = 0;
      n_hit     = 0;
      n_lengths = 0;
    endfunction

    function void set_length(logic [HLEN_W-1:0] v);
      hist_len = 32'(v);
      n_lengths++;
    endfunction

    function int unsigned slot(int unsigned s, int unsigned pos);
      return s * HISTORY_MAX + (oldest[s] + pos) % HISTORY_MAX;
    endfunction

    function int pending();
      return verdicts.size();
    endfunction

    function void note_access(logic [ADDR_IN_W-1:0] addr, logic [SET_IN_W-1:0] set_in);
      logic [LINE_W-1:0] line;
      int unsigned s, len, f, drop, newest, prev;
      bit found, full;
      verdict_t v;
      line  = addr[ADDR_IN_W-1:BLOCK_OFFSET_BITS];
      s     = set_in % SETS;
      len   = hist_len;
      found = 0;
      full  = 0;
      prev  = 0;
      if (len < 1) len = 1;
      if (len > HISTORY_MAX) len = HISTORY_MAX;
      f = fill[s];
      if (f >= len) begin
        drop      = f - (len - 1);
        oldest[s] = (oldest[s] + drop) % HISTORY_MAX;
        f         = f - drop;
      end
      tags[slot(s, f)] = line;
      occ[slot(s, f)]  = '0;
      f++;
      fill[s] = f;
      newest  = f - 1;
      for (int k = newest; k > 0; k--) begin
        if (tags[slot(s, k - 1)] == line) begin
          prev  = k - 1;
          found = 1;
          break;
        end
      end
      if (found) begin
        for (int k = prev; k < newest; k++) begin
          if (occ[slot(s, k)] >= WAYS) begin
            full = 1;
            break;
          end
        end
        if (!full) begin
          for (int k = prev; k < newest; k++) occ[slot(s, k)] = occ[slot(s, k)] + 1'b1;
        end
      end
      v.opt_hit     = found && !full;
      v.reuse_found = found;
      verdicts.insert(verdicts.size(), v);
      n_access++;
      if (found) n_reuse++;
      if (v.opt_hit) n_hit++;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      n_errors++;
    endtask

    task check_result(logic opt_hit, logic reuse_found);
      verdict_t v;
      if (verdicts.size() == 0) begin
        report_mismatch("result strobe with no transaction outstanding");
      end else begin
        v = verdicts[0];
        verdicts.delete(0);
        if (opt_hit !== v.opt_hit)
          report_mismatch($sformatf("opt_hit %b, expected %b", opt_hit, v.opt_hit));
        if (reuse_found !== v.reuse_found)
          report_mismatch($sformatf("reuse_found %b, expected %b",
                                    reuse_found, v.reuse_found));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic [ADDR_IN_W-1:0] byte_address_i;
  logic [SET_IN_W-1:0]  set_index_i;
  logic                 history_length_we_i;
  logic [HLEN_W-1:0]    history_length_i;
  logic                 result_valid_o;
  logic                 opt_hit_o;
  logic                 reuse_found_o;

  oracle_scoreboard sb;

  opt_reuse_window_oracle DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .busy_o              (busy_o),
    .byte_address_i      (byte_address_i),
    .set_index_i         (set_index_i),
    .history_length_we_i (history_length_we_i),
    .history_length_i    (history_length_i),
    .result_valid_o      (result_valid_o),
    .opt_hit_o           (opt_hit_o),
    .reuse_found_o       (reuse_found_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) sb.check_result(opt_hit_o, reuse_found_o);
      if (start_i && !busy_o) sb.note_access(byte_address_i, set_index_i);
      if (history_length_we_i) sb.set_length(history_length_i);
    end
  end

  task automatic send_access(logic [ADDR_IN_W-1:0] addr, logic [SET_IN_W-1:0] set_in,
                             int gap);
    if (gap > 0) begin
      @(negedge clk_i) start_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i        <= 1'b1;
    byte_address_i <= addr;
    set_index_i    <= set_in;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic wait_drained();
    @(negedge clk_i) start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_length(logic [HLEN_W-1:0] v);
    wait_drained();
    @(negedge clk_i);
    history_length_we_i <= 1'b1;
    history_length_i    <= v;
    @(negedge clk_i) history_length_we_i <= 1'b0;
  endtask

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 4) == 0) return $urandom_range(20, 300);
    return $urandom_range(1, 20);
  endfunction

  function automatic logic [ADDR_IN_W-1:0] line_addr(logic [LINE_W-1:0] line);
    logic [BLOCK_OFFSET_BITS-1:0] off;
    off = BLOCK_OFFSET_BITS'($urandom);
    return {line, off};
  endfunction

  // Mostly reuse-heavy bursts on two hot sets (random picks or cyclic scans
  // over a small line pool), with some fully random accesses mixed in.
  task automatic run_phase(int n, int pct);
    int                unsigned hot [2];
    logic [LINE_W-1:0] pool [2][24];
    int                pool_n [2];
    int                cyc [2];
    int                done, burst, h, mode, j;
    logic [ADDR_IN_W-1:0] a;
    logic [SET_IN_W-1:0]  s;
    for (int i = 0; i < 2; i++) begin
      hot[i]    = $urandom_range(0, SETS - 1);
      pool_n[i] = $urandom_range(1, 24);
      cyc[i]    = 0;
      for (int k = 0; k < 24; k++) pool[i][k] = LINE_W'({$urandom, $urandom});
    end
    done = 0;
    while (done < n) begin
      h     = $urandom_range(0, 1);
      mode  = $urandom_range(0, 1);
      burst = $urandom_range(8, 40);
      for (int i = 0; i < burst && done < n; i++) begin
        if ($urandom_range(0, 9) == 0) begin
          a = {$urandom, $urandom};
          s = SET_IN_W'($urandom);
        end else begin
          if (mode != 0) begin
            j      = cyc[h];
            cyc[h] = (cyc[h] + 1) % pool_n[h];
          end else begin
            j = $urandom_range(0, pool_n[h] - 1);
          end
          a = line_addr(pool[h][j]);
          s = SET_IN_W'(hot[h]);
        end
        send_access(a, s, pick_gap(pct));
        done++;
        if (done == n / 2) wait_drained();
      end
    end
  endtask

  initial begin
    int lengths [10];
    int idle_pct [4];
    lengths  = '{128, 2, 255, 0, 17, 64, 1, 200, 33, 128};
    idle_pct = '{0, 47, 0, 19};
    sb = new();
    rst_ni              = 1'b0;
    start_i             = 1'b0;
    byte_address_i      = '0;
    set_index_i         = '0;
    history_length_we_i = 1'b0;
    history_length_i    = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed
    write_length(8'd128);
    send_access(64'h0, 6'd0, 0);
    send_access(64'h3F, 6'd0, 0);
    send_access('1, 6'd63, 0);
    send_access(64'hFFFF_FFFF_FFFF_FFC0, 6'd63, 0);
    send_access(64'h0, 6'd63, 0);
    send_access(64'h40, 6'd0, 0);
    send_access(64'h0, 6'd0, 0);
    for (int i = 0; i < 5; i++) send_access(line_addr(LINE_W'(100 + i)), 6'd10, 0);
    // shrink the window below the fill of set 10
    write_length(8'd2);
    send_access(line_addr(LINE_W'(104)), 6'd10, 0);
    send_access(line_addr(LINE_W'(100)), 6'd10, 0);
    // zero length behaves as one
    write_length(8'd0);
    send_access(64'h0, 6'd0, 0);
    send_access(64'h0, 6'd0, 0);
    // above maximum clamps
    write_length(8'd255);
    send_access(line_addr(LINE_W'(7)), 6'd3, 0);
    send_access(line_addr(LINE_W'(7)), 6'd3, 0);
    write_length(8'd1);
    send_access(line_addr(LINE_W'(7)), 6'd3, 0);

    // random
    for (int p = 0; p < 10; p++) begin
      write_length(HLEN_W'(lengths[p]));
      run_phase(55, idle_pct[p % 4]);
    end

    @(negedge clk_i) start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    $display("Ran %0d accesses under %0d history length settings with varied idling.",
             sb.n_access, sb.n_lengths);
    $display("Reuse found %0d times, OPT hit %0d, saturated misses %0d, mismatches %0d.",
             sb.n_reuse, sb.n_hit, sb.n_reuse - sb.n_hit, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
